>>> hdl/iti_pkg.sv
// iti_pkg: types, codes and helper functions of the init-table interpreter
// used by the sequencer, the destination unit, the top level and the checker
package iti_pkg;

  // parse sequencer phases
  typedef enum logic [2:0] {
    PH_ACTION,
    PH_OFF8,
    PH_OFF24,
    PH_ALIGN,
    PH_DATA,
    PH_EMIT
  } phase_t;

  // ii field of the action byte
  typedef enum logic [1:0] {
    ACT_COPY,
    ACT_REPEAT,
    ACT_OFF8,
    ACT_OFF24
  } act_t;

  // ss field of the action byte
  typedef enum logic [1:0] {
    SZ_LONG,
    SZ_WORD,
    SZ_BYTE,
    SZ_QUAD
  } size_t;

  // write_size codes on the result channel
  localparam logic [1:0] OUT_BYTE = 2'd0;
  localparam logic [1:0] OUT_WORD = 2'd1;
  localparam logic [1:0] OUT_LONG = 2'd2;
  localparam logic [1:0] OUT_QUAD = 2'd3;

  // request to the shared destination adder: add, then clear low bits
  typedef struct packed {
    logic [3:0] addend;
    logic [2:0] clr_mask;
  } dest_op_t;

  typedef struct packed {
    logic [23:0] write_offset;
    logic [63:0] write_data;
    logic [1:0]  write_size;
    logic        last_of_run;
    logic        table_end;
  } result_t;

  function automatic logic [3:0] elem_bytes(input size_t s);
    case (s)
      SZ_LONG: elem_bytes = 4'd4;
      SZ_WORD: elem_bytes = 4'd2;
      SZ_BYTE: elem_bytes = 4'd1;
      SZ_QUAD: elem_bytes = 4'd8;
      default: elem_bytes = 4'd1;
    endcase
  endfunction

  function automatic logic [1:0] size_out(input size_t s);
    case (s)
      SZ_LONG: size_out = OUT_LONG;
      SZ_WORD: size_out = OUT_WORD;
      SZ_BYTE: size_out = OUT_BYTE;
      SZ_QUAD: size_out = OUT_QUAD;
      default: size_out = OUT_BYTE;
    endcase
  endfunction

endpackage

>>> hdl/iti_if.sv
// iti_if: valid/ready channel interfaces of the init-table interpreter
// table byte input channel and element write result channel; no dependencies
interface iti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;

  modport source (output valid, output table_byte, input ready);
  modport sink (input valid, input table_byte, output ready);
endinterface

interface iti_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] write_offset;
  logic [63:0] write_data;
  logic [1:0]  write_size;
  logic        last_of_run;
  logic        table_end;

  modport source (output valid, output write_offset, output write_data, output write_size,
                  output last_of_run, output table_end, input ready);
  modport sink (input valid, input write_offset, input write_data, input write_size,
                input last_of_run, input table_end, output ready);
endinterface

>>> hdl/iti_dest_unit.sv
// iti_dest_unit: shared destination adder, used for alignment round-up and
// for stepping the destination after each element write; uses iti_pkg
module iti_dest_unit #(
  parameter int DEST_OFFSET_BITS = 24
) (
  input  logic [DEST_OFFSET_BITS-1:0] base,
  input  iti_pkg::dest_op_t           op,
  output logic [DEST_OFFSET_BITS-1:0] sum
);

  logic [DEST_OFFSET_BITS-1:0] raw;

  // wraps modulo 2^DEST_OFFSET_BITS by width
  assign raw = base + DEST_OFFSET_BITS'(op.addend);
  assign sum = raw & ~(DEST_OFFSET_BITS'(op.clr_mask));

endmodule

>>> hdl/iti_seq.sv
// iti_seq: parse sequencer of the init-table interpreter; decodes action,
// offset, padding and data bytes and steps out element writes; uses iti_pkg
module iti_seq #(
  parameter int LONG_ALIGN       = 4,
  parameter int WORD_ALIGN       = 2,
  parameter int QUAD_ALIGN       = 8,
  parameter int DEST_OFFSET_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_be,
  input  logic                        in_valid,
  input  logic [7:0]                  in_byte,
  output logic                        in_ready,
  output logic                        emit_valid,
  output iti_pkg::result_t            emit_res,
  input  logic                        emit_take,
  output logic [DEST_OFFSET_BITS-1:0] dest_base,
  output iti_pkg::dest_op_t           dest_op,
  input  logic [DEST_OFFSET_BITS-1:0] dest_sum
);

  localparam logic [2:0] LONG_M = 3'(LONG_ALIGN - 1);
  localparam logic [2:0] WORD_M = 3'(WORD_ALIGN - 1);
  localparam logic [2:0] QUAD_M = 3'(QUAD_ALIGN - 1);

  function automatic logic [2:0] align_m(input iti_pkg::size_t s);
    case (s)
      iti_pkg::SZ_LONG: align_m = LONG_M;
      iti_pkg::SZ_WORD: align_m = WORD_M;
      iti_pkg::SZ_BYTE: align_m = 3'd0;
      iti_pkg::SZ_QUAD: align_m = QUAD_M;
      default:          align_m = 3'd0;
    endcase
  endfunction

  iti_pkg::phase_t             phase_r, phase_nxt;
  iti_pkg::act_t               act_r, act_nxt;
  iti_pkg::size_t              size_r, size_nxt;
  logic [4:0]                  left_r, left_nxt;
  logic [2:0]                  pos_r, pos_nxt;
  logic [DEST_OFFSET_BITS-1:0] dest_r, dest_nxt;
  logic [23:0]                 offs_r, offs_nxt;
  logic [63:0]                 elem_r, elem_nxt;
  logic [2:0]                  bcnt_r, bcnt_nxt;
  logic                        end_r, end_nxt;

  iti_pkg::act_t               new_act;
  iti_pkg::size_t              new_size;
  logic [2:0]                  pos_inc;
  logic [2:0]                  bcnt_inc;
  logic [3:0]                  eb;
  logic                        fire;

  assign new_act   = iti_pkg::act_t'(in_byte[7:6]);
  assign new_size  = iti_pkg::size_t'(in_byte[5:4]);
  assign pos_inc   = pos_r + 3'd1;
  assign bcnt_inc  = bcnt_r + 3'd1;
  assign eb        = iti_pkg::elem_bytes(size_r);
  assign in_ready  = (phase_r != iti_pkg::PH_EMIT);
  assign fire      = in_valid && in_ready;
  assign dest_base = dest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= iti_pkg::PH_ACTION;
      act_r   <= iti_pkg::ACT_COPY;
      size_r  <= iti_pkg::SZ_LONG;
      left_r  <= '0;
      pos_r   <= '0;
      dest_r  <= '0;
      bcnt_r  <= '0;
      end_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      size_r  <= size_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      dest_r  <= dest_nxt;
      bcnt_r  <= bcnt_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offs_r <= offs_nxt;
    elem_r <= elem_nxt;
  end

  always_comb begin
    phase_nxt  = phase_r;
    act_nxt    = act_r;
    size_nxt   = size_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    dest_nxt   = dest_r;
    offs_nxt   = offs_r;
    elem_nxt   = elem_r;
    bcnt_nxt   = bcnt_r;
    end_nxt    = end_r;
    dest_op    = '{addend: 4'd0, clr_mask: 3'd0};
    emit_valid = 1'b0;
    emit_res   = '0;

    case (phase_r)
      iti_pkg::PH_ACTION: begin
        // round-up request for copy and repeat actions
        dest_op = '{addend: {1'b0, align_m(new_size)}, clr_mask: align_m(new_size)};
        if (fire) begin
          if ((pos_r & WORD_M) != 3'd0) begin
            pos_nxt = pos_inc;
          end else if (in_byte == 8'd0) begin
            pos_nxt   = '0;
            dest_nxt  = '0;
            end_nxt   = 1'b1;
            phase_nxt = iti_pkg::PH_EMIT;
          end else begin
            act_nxt  = new_act;
            size_nxt = new_size;
            left_nxt = {1'b0, in_byte[3:0]} + 5'd1;
            pos_nxt  = pos_inc;
            case (new_act)
              iti_pkg::ACT_COPY, iti_pkg::ACT_REPEAT: begin
                dest_nxt  = dest_sum;
                bcnt_nxt  = '0;
                elem_nxt  = '0;
                phase_nxt = ((pos_inc & align_m(new_size)) == 3'd0) ?
                            iti_pkg::PH_DATA : iti_pkg::PH_ALIGN;
              end
              iti_pkg::ACT_OFF8: begin
                phase_nxt = iti_pkg::PH_OFF8;
              end
              default: begin
                phase_nxt = iti_pkg::PH_OFF24;
                offs_nxt  = '0;
                bcnt_nxt  = '0;
              end
            endcase
          end
        end
      end

      iti_pkg::PH_OFF8: begin
        if (fire) begin
          pos_nxt   = pos_inc;
          dest_nxt  = DEST_OFFSET_BITS'(in_byte);
          bcnt_nxt  = '0;
          elem_nxt  = '0;
          phase_nxt = ((pos_inc & align_m(size_r)) == 3'd0) ?
                      iti_pkg::PH_DATA : iti_pkg::PH_ALIGN;
        end
      end

      iti_pkg::PH_OFF24: begin
        if (fire) begin
          pos_nxt  = pos_inc;
          offs_nxt = cfg_be ? {offs_r[15:0], in_byte} :
                     (offs_r | (24'(in_byte) << {bcnt_r[1:0], 3'b000}));
          bcnt_nxt = bcnt_inc;
          if (bcnt_r == 3'd2) begin
            dest_nxt  = DEST_OFFSET_BITS'(offs_nxt);
            bcnt_nxt  = '0;
            elem_nxt  = '0;
            phase_nxt = ((pos_inc & align_m(size_r)) == 3'd0) ?
                        iti_pkg::PH_DATA : iti_pkg::PH_ALIGN;
          end
        end
      end

      iti_pkg::PH_ALIGN: begin
        if (fire) begin
          pos_nxt = pos_inc;
          if ((pos_inc & align_m(size_r)) == 3'd0) begin
            phase_nxt = iti_pkg::PH_DATA;
          end
        end
      end

      iti_pkg::PH_DATA: begin
        if (fire) begin
          pos_nxt                          = pos_inc;
          elem_nxt[{bcnt_r, 3'b000} +: 8]  = in_byte;
          bcnt_nxt                         = bcnt_inc;
          // a quad wraps the byte count back to zero
          if (bcnt_inc == eb[2:0]) begin
            phase_nxt = iti_pkg::PH_EMIT;
          end
        end
      end

      iti_pkg::PH_EMIT: begin
        emit_valid = 1'b1;
        dest_op    = '{addend: eb, clr_mask: 3'd0};
        if (end_r) begin
          emit_res.last_of_run = 1'b1;
          emit_res.table_end   = 1'b1;
        end else begin
          emit_res.write_offset = dest_r[23:0];
          emit_res.write_data   = elem_r;
          emit_res.write_size   = iti_pkg::size_out(size_r);
          emit_res.last_of_run  = (act_r != iti_pkg::ACT_REPEAT) || (left_r == 5'd1);
        end
        if (emit_take) begin
          if (end_r) begin
            end_nxt   = 1'b0;
            phase_nxt = iti_pkg::PH_ACTION;
          end else begin
            dest_nxt = dest_sum;
            left_nxt = left_r - 5'd1;
            if (emit_res.last_of_run) begin
              elem_nxt  = '0;
              bcnt_nxt  = '0;
              phase_nxt = (left_r == 5'd1) ? iti_pkg::PH_ACTION : iti_pkg::PH_DATA;
            end
          end
        end
      end

      default: begin
        phase_nxt = iti_pkg::PH_ACTION;
      end
    endcase
  end

endmodule

>>> hdl/init_table_interpreter.sv
// init_table_interpreter: top level; byte order register, parse sequencer,
// shared destination adder and the result output register
// depends on iti_pkg, iti_if, iti_seq and iti_dest_unit
//
// Usage: table bytes enter on in_ch (valid/ready, table_byte) in table order.
// Each copy or repeat element comes out on out_ch as one write transaction:
// write_offset from the destination base, write_data with byte k at offset+k,
// write_size, last_of_run on an element's last write, and table_end on the
// single result of a zero action byte (destination and position restart).
// Action, offset, padding and data bytes are taken one per cycle. The byte
// that completes an element then holds in_ch.ready low while the writes it
// causes go out: one for a copy, up to sixteen for a repeat, as the one
// destination adder steps the offset a write at a time. A result waits in
// the output register, so the next table byte is taken while it is pending;
// a stalled out_ch holds the write sequence and, through it, the input.
// Each write passes from the emit phase through the output register.
// cfg_wr_en/cfg_wr_data set the 24-bit offset byte order (1: most
// significant first); write it only while idle.
// Reset (rst_n low, synchronous) returns to expect an action byte at
// table position 0, destination 0, little-endian offsets, output empty.
module init_table_interpreter #(
  parameter int LONG_ALIGN       = 4,
  parameter int WORD_ALIGN       = 2,
  parameter int QUAD_ALIGN       = 8,
  parameter int DEST_OFFSET_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  iti_in_if.sink   in_ch,
  iti_out_if.source out_ch
);

  logic                        cfg_be_r;
  logic                        out_valid_r;
  iti_pkg::result_t            out_res_r;
  logic                        emit_valid;
  iti_pkg::result_t            emit_res;
  logic                        emit_take;
  logic [DEST_OFFSET_BITS-1:0] dest_base;
  logic [DEST_OFFSET_BITS-1:0] dest_sum;
  iti_pkg::dest_op_t           dest_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_be_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_be_r <= cfg_wr_data;
    end
  end

  iti_seq #(
    .LONG_ALIGN       (LONG_ALIGN),
    .WORD_ALIGN       (WORD_ALIGN),
    .QUAD_ALIGN       (QUAD_ALIGN),
    .DEST_OFFSET_BITS (DEST_OFFSET_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_be     (cfg_be_r),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.table_byte),
    .in_ready   (in_ch.ready),
    .emit_valid (emit_valid),
    .emit_res   (emit_res),
    .emit_take  (emit_take),
    .dest_base  (dest_base),
    .dest_op    (dest_op),
    .dest_sum   (dest_sum)
  );

  iti_dest_unit #(
    .DEST_OFFSET_BITS (DEST_OFFSET_BITS)
  ) u_dest (
    .base (dest_base),
    .op   (dest_op),
    .sum  (dest_sum)
  );

  // output register frees up in the cycle it is taken
  assign emit_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_valid && emit_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_take) begin
      out_res_r <= emit_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_offset = out_res_r.write_offset;
  assign out_ch.write_data   = out_res_r.write_data;
  assign out_ch.write_size   = out_res_r.write_size;
  assign out_ch.last_of_run  = out_res_r.last_of_run;
  assign out_ch.table_end    = out_res_r.table_end;

endmodule

>>> hdl/iti_checker.sv
// iti_checker: port-level assertions for init_table_interpreter
// attached by bind; depends on iti_pkg
module iti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] write_offset,
  input logic [63:0] write_data,
  input logic [1:0]  write_size,
  input logic        last_of_run,
  input logic        table_end
);

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(write_offset) &&
    $stable(write_data) && $stable(write_size) && $stable(last_of_run) &&
    $stable(table_end))
    else $error("result changed while stalled");

  // end of table carries no write and closes the run
  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_end |-> last_of_run && write_offset == 24'd0 &&
    write_data == 64'd0 && write_size == iti_pkg::OUT_BYTE)
    else $error("end of table result with write fields");

  // bytes above the element size stay zero
  a_data_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !table_end |->
    (write_size == iti_pkg::OUT_QUAD) ||
    (write_size == iti_pkg::OUT_LONG && write_data[63:32] == 32'd0) ||
    (write_size == iti_pkg::OUT_WORD && write_data[63:16] == 48'd0) ||
    (write_size == iti_pkg::OUT_BYTE && write_data[63:8] == 56'd0))
    else $error("element data wider than its size");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind init_table_interpreter iti_checker u_iti_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .write_offset (out_ch.write_offset),
  .write_data   (out_ch.write_data),
  .write_size   (out_ch.write_size),
  .last_of_run  (out_ch.last_of_run),
  .table_end    (out_ch.table_end)
);
